### hw/rtl/rc4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

    localparam int BOX_SIZE    = 256;
    localparam int BOX_W       = $clog2(BOX_SIZE);
    localparam int KEY_MAX_DEF = 256;

    // Codes carried in the tuser bit of an input transfer.
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef logic [7:0] t_byte;

    // One access to the permutation box; a read and a write never share a cycle.
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [BOX_W-1:0] addr;
        t_byte            wdata;
    } t_box_req;

    // One key byte to store; start marks the first byte of a new key.
    typedef struct packed {
        logic  wr;
        logic  start;
        t_byte data;
    } t_key_wr;

endpackage

`default_nettype wire

### hw/rtl/rc4_stream_cipher_core.sv
// RC4 stream cipher core.
// Input channel (i_s_*): tuser selects the kind of item: 0 loads a key byte,
// 1 ciphers a data byte. tdata carries the byte, tlast ends a key or a message.
// A key byte is written to the key store as it is taken. The key byte with
// tlast set starts the key schedule, with tready low: a fill pass writes the
// identity into all 256 box entries, then 256 schedule steps swap S[i], S[j].
// A data byte walks the single-port box through read i, read j, two swap
// writes and the keystream read, then the result goes to the output
// register. tready stays low until the core is back in idle, so a new
// byte is taken only once the last one is through. Before any key the
// keystream is zero and a data byte goes straight to the output step.
// Output channel (o_m_*): tdata is the ciphered byte, tlast copies the
// input tlast. The result sits in an output register, so the core takes the
// next input while it waits; a further result holds in the core until the
// receiver takes the first one.
// Reset (synchronous, active low) clears the indices, the key count and
// the keyed state; no clearing pass runs over the box or the key store.
// A data byte during an unfinished key abandons that key.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_core #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire rc4_pkg::t_byte i_s_tdata,   // [7:0] byte_in
    input  wire logic           i_s_tlast,   // last
    input  wire logic           i_s_tuser,   // [0] mode
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output rc4_pkg::t_byte      o_m_tdata,   // [7:0] out_byte
    output logic                o_m_tlast    // out_last
);
    import rc4_pkg::*;

    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CNT_W  = $clog2(KEY_MAX + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_KS_RD  = 4'd2;
    localparam logic [3:0] S_KS_J   = 4'd3;
    localparam logic [3:0] S_KS_W1  = 4'd4;
    localparam logic [3:0] S_KS_W2  = 4'd5;
    localparam logic [3:0] S_D_RDI  = 4'd6;
    localparam logic [3:0] S_D_J    = 4'd7;
    localparam logic [3:0] S_D_W1   = 4'd8;
    localparam logic [3:0] S_D_W2   = 4'd9;
    localparam logic [3:0] S_D_RDK  = 4'd10;
    localparam logic [3:0] S_D_OUT  = 4'd11;

    localparam logic [BOX_W-1:0] IDX_LAST = BOX_W'(BOX_SIZE - 1);

    logic [3:0]        r_state,   n_state;
    logic [BOX_W-1:0]  r_i,       n_i;
    logic [BOX_W-1:0]  r_j,       n_j;
    logic [KIDX_W-1:0] r_kidx,    n_kidx;
    logic              r_keyed,   n_keyed;
    logic              r_key_loading, n_key_loading;
    logic              r_out_valid, n_out_valid;
    t_byte             r_si,      n_si;
    t_byte             r_sj,      n_sj;
    t_byte             r_byte,    n_byte;
    logic              r_last,    n_last;
    t_byte             r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    t_box_req          box_req;
    t_byte             box_rdata;
    t_key_wr           key_wr;
    t_byte             key_rdata;
    logic [CNT_W-1:0]  key_count;

    t_byte             add_a, add_b, add_c;
    t_byte             add_sum;
    logic              s_acc;
    logic              out_free;

    rc4_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (box_req),
        .o_rdata (box_rdata)
    );

    rc4_keystore #(
        .KEY_MAX (KEY_MAX),
        .KIDX_W  (KIDX_W),
        .CNT_W   (CNT_W)
    ) u_keystore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (key_wr),
        .i_raddr (r_kidx),
        .o_rdata (key_rdata),
        .o_count (key_count)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // Shared index adder: j update in the schedule and the generator, and
    // the keystream index in the generator.
    always_comb begin
        add_a = r_j;
        add_b = box_rdata;
        add_c = 8'h00;
        case (r_state)
            S_KS_J:  add_c = key_rdata;
            S_D_RDK: begin
                add_a = r_si;
                add_b = r_sj;
            end
            default: add_c = 8'h00;
        endcase
        add_sum = add_a + add_b + add_c;
    end

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_j           = r_j;
        n_kidx        = r_kidx;
        n_keyed       = r_keyed;
        n_key_loading = r_key_loading;
        n_si          = r_si;
        n_sj          = r_sj;
        n_byte        = r_byte;
        n_last        = r_last;
        n_out_data    = r_out_data;
        n_out_last    = r_out_last;
        n_out_valid   = i_m_tready ? 1'b0 : r_out_valid;
        box_req       = '0;
        key_wr.wr     = 1'b0;
        key_wr.start  = !r_key_loading;
        key_wr.data   = i_s_tdata;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == MODE_KEY) begin
                        key_wr.wr = 1'b1;
                        if (i_s_tlast) begin
                            n_key_loading = 1'b0;
                            n_i           = '0;
                            n_state       = S_FILL;
                        end else begin
                            n_key_loading = 1'b1;
                        end
                    end else begin
                        n_key_loading = 1'b0;
                        n_byte        = i_s_tdata;
                        n_last        = i_s_tlast;
                        n_i           = r_i + BOX_W'(1);
                        n_state       = r_keyed ? S_D_RDI : S_D_OUT;
                    end
                end
            end
            S_FILL: begin
                box_req.wr    = 1'b1;
                box_req.addr  = r_i;
                box_req.wdata = r_i;
                n_i           = r_i + BOX_W'(1);
                if (r_i == IDX_LAST) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = S_KS_RD;
                end
            end
            S_KS_RD: begin
                box_req.rd   = 1'b1;
                box_req.addr = r_i;
                n_state      = S_KS_J;
            end
            S_KS_J: begin
                n_si         = box_rdata;
                n_j          = add_sum;
                box_req.rd   = 1'b1;
                box_req.addr = add_sum;
                n_state      = S_KS_W1;
            end
            S_KS_W1: begin
                box_req.wr    = 1'b1;
                box_req.addr  = r_i;
                box_req.wdata = box_rdata;
                n_state       = S_KS_W2;
            end
            S_KS_W2: begin
                box_req.wr    = 1'b1;
                box_req.addr  = r_j;
                box_req.wdata = r_si;
                // Key index wraps at the key length instead of a modulo.
                if (CNT_W'(r_kidx) + CNT_W'(1) >= key_count) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + KIDX_W'(1);
                end
                if (r_i == IDX_LAST) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + BOX_W'(1);
                    n_state = S_KS_RD;
                end
            end
            S_D_RDI: begin
                box_req.rd   = 1'b1;
                box_req.addr = r_i;
                n_state      = S_D_J;
            end
            S_D_J: begin
                n_si         = box_rdata;
                n_j          = add_sum;
                box_req.rd   = 1'b1;
                box_req.addr = add_sum;
                n_state      = S_D_W1;
            end
            S_D_W1: begin
                n_sj          = box_rdata;
                box_req.wr    = 1'b1;
                box_req.addr  = r_i;
                box_req.wdata = box_rdata;
                n_state       = S_D_W2;
            end
            S_D_W2: begin
                box_req.wr    = 1'b1;
                box_req.addr  = r_j;
                box_req.wdata = r_si;
                n_state       = S_D_RDK;
            end
            S_D_RDK: begin
                box_req.rd   = 1'b1;
                box_req.addr = add_sum;
                n_state      = S_D_OUT;
            end
            S_D_OUT: begin
                if (out_free) begin
                    n_out_data  = r_byte ^ (r_keyed ? box_rdata : 8'h00);
                    n_out_last  = r_last;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_i           <= '0;
            r_j           <= '0;
            r_kidx        <= '0;
            r_keyed       <= 1'b0;
            r_key_loading <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_i           <= n_i;
            r_j           <= n_j;
            r_kidx        <= n_kidx;
            r_keyed       <= n_keyed;
            r_key_loading <= n_key_loading;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_sched_end_clears_idx: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KS_W2 && r_i == IDX_LAST) |=> (r_i == '0 && r_j == '0 && r_keyed))
        else $error("indices not cleared at the end of the key schedule");

    a_result_from_out_state: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_D_OUT)
        else $error("result loaded outside the output state");

    a_key_present_for_sched: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KS_RD) |-> key_count != '0)
        else $error("key schedule running without key bytes");

endmodule

`default_nettype wire

### hw/rtl/rc4_sbox.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4_sbox (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rc4_pkg::t_box_req i_req,
    output rc4_pkg::t_byte         o_rdata
);
    import rc4_pkg::*;

    t_byte  r_mem [BOX_SIZE];
    t_byte  r_rdata;

    // The read register holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

    a_no_rd_wr_same_cycle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !(i_req.rd && i_req.wr))
        else $error("box read and write issued in the same cycle");

endmodule

`default_nettype wire

### hw/rtl/rc4_keystore.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4_keystore #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF,
    parameter int KIDX_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1,
    parameter int CNT_W   = $clog2(KEY_MAX + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rc4_pkg::t_key_wr i_wr,
    input  wire logic [KIDX_W-1:0] i_raddr,
    output rc4_pkg::t_byte        o_rdata,
    output logic [CNT_W-1:0]      o_count
);
    import rc4_pkg::*;

    t_byte             r_mem [KEY_MAX];
    t_byte             r_rdata;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_en;
    logic [KIDX_W-1:0] w_addr;

    // Bytes beyond the store depth are dropped and the count saturates.
    always_comb begin
        n_count = r_count;
        w_en    = 1'b0;
        w_addr  = r_count[KIDX_W-1:0];
        if (i_wr.wr) begin
            if (i_wr.start) begin
                w_en    = 1'b1;
                w_addr  = '0;
                n_count = CNT_W'(1);
            end else if (r_count < CNT_W'(KEY_MAX)) begin
                w_en    = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

    a_count_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CNT_W'(KEY_MAX))
        else $error("key count beyond store depth");

endmodule

`default_nettype wire
